// ----- src/qsp_pkg.sv -----
package qsp_pkg;

  // Width of the saturating parameter counter.
  localparam int COUNT_WIDTH = 16;
  // Entries in the queue between the classifier and the output side.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
  // One input byte causes at most this many results.
  localparam int MAX_RESULTS = 4;
  localparam int RES_CW = $clog2(MAX_RESULTS + 1);
  localparam int RES_IW = $clog2(MAX_RESULTS);

  localparam logic [7:0] CH_AMP = 8'h26;
  localparam logic [7:0] CH_EQ = 8'h3D;
  localparam logic [7:0] CH_PCT = 8'h25;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Register addresses (word index taken from paddr[2]).
  localparam logic REG_SKIP_TO_QUERY = 1'b0;
  localparam logic REG_DECODE_PLUS = 1'b1;

  typedef enum logic [1:0] {
    PH_START,
    PH_SKIP,
    PH_KEY,
    PH_VALUE
  } qsp_phase_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic byte_valid;
    logic in_value;
    logic param_end;
    logic input_end;
    logic [15:0] param_total;
  } qsp_result_t;

  // All results caused by one input byte, in order; cnt is 1..MAX_RESULTS.
  typedef struct packed {
    logic [RES_CW-1:0] cnt;
    qsp_result_t [MAX_RESULTS-1:0] res;
  } qsp_bundle_t;

  function automatic qsp_result_t make_res(input logic [7:0] b, input logic valid,
                                           input logic inval, input logic pend,
                                           input logic iend, input logic [15:0] total);
    qsp_result_t r;
    r.out_byte = b;
    r.byte_valid = valid;
    r.in_value = inval;
    r.param_end = pend;
    r.input_end = iend;
    r.param_total = total;
    return r;
  endfunction

  // Hex digit value; any other byte stands for itself.
  function automatic logic [7:0] nibble(input logic [7:0] c);
    logic [7:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = c - 8'h57;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = c - 8'h37;
    end else begin
      v = c;
    end
    return v;
  endfunction

  function automatic logic [7:0] plus_map(input logic [7:0] c, input logic dp);
    return (dp && c == CH_PLUS) ? CH_SPACE : c;
  endfunction

endpackage

// ----- src/qsp_front.sv -----
module qsp_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [7:0]           in_byte,
  input  logic                 is_last,
  input  logic                 skip_to_query,
  input  logic                 decode_plus,
  output logic                 push,
  output qsp_pkg::qsp_bundle_t bundle
);

  qsp_pkg::qsp_phase_t phase, phase_next;
  logic [1:0] held_count, held_count_next;
  logic [7:0] held_digit, held_digit_next;
  logic [qsp_pkg::COUNT_WIDTH-1:0] param_counter, param_counter_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= qsp_pkg::PH_START;
      held_count <= 2'd0;
      held_digit <= 8'd0;
      param_counter <= '0;
    end else if (accept) begin
      phase <= phase_next;
      held_count <= held_count_next;
      held_digit <= held_digit_next;
      param_counter <= param_counter_next;
    end
  end

  // Works one byte through the parser and lists the results it causes.
  always_comb begin
    qsp_pkg::qsp_phase_t ph;
    logic [qsp_pkg::RES_CW-1:0] n;
    logic [7:0] dec;
    ph = phase;
    held_count_next = held_count;
    held_digit_next = held_digit;
    param_counter_next = param_counter;
    n = '0;
    bundle = '0;
    if (phase == qsp_pkg::PH_START) begin
      ph = skip_to_query ? qsp_pkg::PH_SKIP : qsp_pkg::PH_KEY;
      held_count_next = 2'd0;
      held_digit_next = 8'd0;
      param_counter_next = '0;
    end
    phase_next = ph;
    dec = 8'((qsp_pkg::nibble(held_digit_next) << 4) + qsp_pkg::nibble(in_byte));

    if (ph == qsp_pkg::PH_SKIP) begin
      if (in_byte == qsp_pkg::CH_QMARK) begin
        phase_next = qsp_pkg::PH_KEY;
        if (is_last) begin
          if (param_counter_next != '1) param_counter_next = param_counter_next + 1'b1;
          bundle.res[n[qsp_pkg::RES_IW-1:0]] =
            qsp_pkg::make_res(8'd0, 1'b0, 1'b0, 1'b1, 1'b1, 16'(param_counter_next));
          n = n + 1'b1;
        end
      end else if (is_last) begin
        param_counter_next = '0;
        bundle.res[n[qsp_pkg::RES_IW-1:0]] =
          qsp_pkg::make_res(8'd0, 1'b0, 1'b0, 1'b0, 1'b1, 16'd0);
        n = n + 1'b1;
      end
    end else begin
      if (ph == qsp_pkg::PH_KEY) begin
        if (in_byte == qsp_pkg::CH_AMP) begin
          if (param_counter_next != '1) param_counter_next = param_counter_next + 1'b1;
          bundle.res[n[qsp_pkg::RES_IW-1:0]] =
            qsp_pkg::make_res(8'd0, 1'b0, 1'b0, 1'b1, 1'b0, 16'(param_counter_next));
          n = n + 1'b1;
        end else if (in_byte == qsp_pkg::CH_EQ) begin
          phase_next = qsp_pkg::PH_VALUE;
        end else begin
          bundle.res[n[qsp_pkg::RES_IW-1:0]] =
            qsp_pkg::make_res(in_byte, 1'b1, 1'b0, 1'b0, 1'b0, 16'(param_counter_next));
          n = n + 1'b1;
        end
      end else if (in_byte == qsp_pkg::CH_AMP) begin
        // A pending escape is written out literally before the parameter closes.
        if (held_count_next >= 2'd1) begin
          bundle.res[n[qsp_pkg::RES_IW-1:0]] =
            qsp_pkg::make_res(qsp_pkg::CH_PCT, 1'b1, 1'b1, 1'b0, 1'b0,
                              16'(param_counter_next));
          n = n + 1'b1;
        end
        if (held_count_next >= 2'd2) begin
          bundle.res[n[qsp_pkg::RES_IW-1:0]] =
            qsp_pkg::make_res(qsp_pkg::plus_map(held_digit_next, decode_plus), 1'b1, 1'b1,
                              1'b0, 1'b0, 16'(param_counter_next));
          n = n + 1'b1;
        end
        held_count_next = 2'd0;
        held_digit_next = 8'd0;
        if (param_counter_next != '1) param_counter_next = param_counter_next + 1'b1;
        bundle.res[n[qsp_pkg::RES_IW-1:0]] =
          qsp_pkg::make_res(8'd0, 1'b0, 1'b0, 1'b1, 1'b0, 16'(param_counter_next));
        n = n + 1'b1;
        phase_next = qsp_pkg::PH_KEY;
      end else if (held_count_next == 2'd0) begin
        if (in_byte == qsp_pkg::CH_PCT) begin
          held_count_next = 2'd1;
        end else begin
          bundle.res[n[qsp_pkg::RES_IW-1:0]] =
            qsp_pkg::make_res(qsp_pkg::plus_map(in_byte, decode_plus), 1'b1, 1'b1,
                              1'b0, 1'b0, 16'(param_counter_next));
          n = n + 1'b1;
        end
      end else if (held_count_next == 2'd1) begin
        held_digit_next = in_byte;
        held_count_next = 2'd2;
      end else begin
        bundle.res[n[qsp_pkg::RES_IW-1:0]] =
          qsp_pkg::make_res(dec, 1'b1, 1'b1, 1'b0, 1'b0, 16'(param_counter_next));
        n = n + 1'b1;
        held_count_next = 2'd0;
        held_digit_next = 8'd0;
      end
      if (is_last) begin
        if (held_count_next >= 2'd1) begin
          bundle.res[n[qsp_pkg::RES_IW-1:0]] =
            qsp_pkg::make_res(qsp_pkg::CH_PCT, 1'b1, 1'b1, 1'b0, 1'b0,
                              16'(param_counter_next));
          n = n + 1'b1;
        end
        if (held_count_next >= 2'd2) begin
          bundle.res[n[qsp_pkg::RES_IW-1:0]] =
            qsp_pkg::make_res(qsp_pkg::plus_map(held_digit_next, decode_plus), 1'b1, 1'b1,
                              1'b0, 1'b0, 16'(param_counter_next));
          n = n + 1'b1;
        end
        if (param_counter_next != '1) param_counter_next = param_counter_next + 1'b1;
        bundle.res[n[qsp_pkg::RES_IW-1:0]] =
          qsp_pkg::make_res(8'd0, 1'b0, 1'b0, 1'b1, 1'b1, 16'(param_counter_next));
        n = n + 1'b1;
      end
    end

    if (is_last) begin
      phase_next = qsp_pkg::PH_START;
      held_count_next = 2'd0;
      held_digit_next = 8'd0;
      param_counter_next = '0;
    end
    bundle.cnt = n;
    push = accept && (n != '0);
  end

endmodule

// ----- src/qsp_queue.sv -----
module qsp_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  qsp_pkg::qsp_bundle_t wr_data,
  input  logic                 pop,
  output qsp_pkg::qsp_bundle_t rd_data,
  output logic                 not_empty,
  output logic                 full
);

  qsp_pkg::qsp_bundle_t entries [qsp_pkg::QUEUE_DEPTH];
  logic [qsp_pkg::QUEUE_AW-1:0] wr_ptr, rd_ptr;
  logic [qsp_pkg::QUEUE_AW:0] fill;

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  assign rd_data = entries[rd_ptr];
  assign not_empty = (fill != '0);
  assign full = (fill == (qsp_pkg::QUEUE_AW + 1)'(qsp_pkg::QUEUE_DEPTH));

endmodule

// ----- src/qsp_back.sv -----
module qsp_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 head_valid,
  input  qsp_pkg::qsp_bundle_t head,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output qsp_pkg::qsp_result_t out_res
);

  logic [qsp_pkg::RES_IW-1:0] idx;
  logic load, at_end;

  assign load = head_valid && (!out_valid || out_ready);
  assign at_end = ({1'b0, idx} + 1'b1) == head.cnt;
  assign pop = load && at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx <= at_end ? '0 : idx + 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_res <= head.res[idx];
  end

  a_head_count: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> (head.cnt != '0 && head.cnt <= qsp_pkg::RES_CW'(qsp_pkg::MAX_RESULTS)))
    else $error("queued request holds no results");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> ({1'b0, idx} < head.cnt))
    else $error("result index beyond the queued request");

  a_idx_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(idx))
    else $error("result index moved while output stalled");

  a_idle_idx: assert property (@(posedge clk) disable iff (rst)
    !head_valid |-> (idx == '0))
    else $error("result index left nonzero with queue empty");

endmodule

// ----- src/query_string_parser.sv -----
// Query/form string parser with percent decoding. Bytes of the string enter on the s_ stream,
// one request per byte with s_tlast on the final byte; results leave on the m_ stream as key
// bytes, value bytes (percent escapes and, if enabled, plus signs decoded) and markers that end
// a parameter or the string. A classifier takes one byte per cycle while the queue is not full and
// queues the zero to four results that byte causes; the output side hands them out one per cycle
// from a registered stage while m_tready is high. So input is taken every cycle as long as results
// come out as fast as they are made; the sustained rate is set by the output port at one result per
// cycle, and the first result of a byte passes through the queue and the output register before
// m_tvalid shows it. The four-entry queue lets either side stall on its own. Register 0 (address 0,
// skip_to_query, reset 1) makes the parser discard everything through the first question mark;
// register 1 (address 4, decode_plus, reset 1) turns a plus sign in a value into a space.
// skip_to_query is taken when a string starts, decode_plus as each value byte is decoded; both are
// to be written only while the block is idle, and the block itself does not enforce this.
module query_string_parser (
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,  // [7:0] in_byte
  input  logic        s_tlast,  // is_last
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,  // [7:0] out_byte, [23:8] param_total
  output logic [2:0]  m_tuser,  // [0] byte_valid, [1] in_value, [2] param_end
  output logic        m_tlast,  // input_end
  // Register port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic skip_to_query, decode_plus;
  logic accept, push, pop, q_not_empty, q_full;
  qsp_pkg::qsp_bundle_t wr_bundle, head;
  qsp_pkg::qsp_result_t out_res;

  // Configuration registers; the word is picked by paddr[2] alone.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      skip_to_query <= 1'b1;
      decode_plus <= 1'b1;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == qsp_pkg::REG_DECODE_PLUS) begin
        decode_plus <= pwdata[0];
      end else begin
        skip_to_query <= pwdata[0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == qsp_pkg::REG_SKIP_TO_QUERY) begin
      prdata[0] = skip_to_query;
    end else begin
      prdata[0] = decode_plus;
    end
  end

  // A byte is taken whenever the queue has room for the request it may make.
  assign s_tready = !q_full;
  assign accept = s_tvalid && s_tready;

  qsp_front u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .in_byte       (s_tdata),
    .is_last       (s_tlast),
    .skip_to_query (skip_to_query),
    .decode_plus   (decode_plus),
    .push          (push),
    .bundle        (wr_bundle)
  );

  qsp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_data   (wr_bundle),
    .pop       (pop),
    .rd_data   (head),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  qsp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_not_empty),
    .head       (head),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_res    (out_res)
  );

  assign m_tdata = {out_res.param_total, out_res.out_byte};
  assign m_tuser = {out_res.param_end, out_res.in_value, out_res.byte_valid};
  assign m_tlast = out_res.input_end;

endmodule

// ----- sim/query_string_parser_tb.sv -----
module query_string_parser_tb;

  // Cycles allowed for bytes that cause no result to leave the pipeline
  // before the block is treated as idle.
  localparam int DRAIN_CYCLES = 12;
  localparam int REPORT_LIMIT = 10;
  localparam logic [31:0] COUNT_MAX = (32'd1 << qsp_pkg::COUNT_WIDTH) - 32'd1;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [7:0] in_byte
  logic        s_tlast;   // is_last
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;   // [7:0] out_byte, [23:8] param_total
  logic [2:0]  m_tuser;   // [0] byte_valid, [1] in_value, [2] param_end
  logic        m_tlast;   // input_end
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  query_string_parser uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Chances, in percent, that the sender idles or the receiver stalls in a cycle.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;

  // Results the parser is expected to produce, oldest first.
  qsp_pkg::qsp_result_t expected_results[$];

  // Shadow copy of the parser: its registers and its per-string state.
  logic                cfg_skip;
  logic                cfg_plus;
  qsp_pkg::qsp_phase_t cur_phase;
  logic [1:0]          esc_held;
  logic [7:0]          esc_first;
  logic [31:0]         params_done;
  int                  caused;

  function automatic string fmt_result(input qsp_pkg::qsp_result_t r);
    return $sformatf("byte=%02h valid=%0b value=%0b pend=%0b iend=%0b total=%0d",
                     r.out_byte, r.byte_valid, r.in_value, r.param_end, r.input_end,
                     r.param_total);
  endfunction

  function automatic void report_error(input string msg);
    errors++;
    if (errors <= REPORT_LIMIT) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
  endfunction

  // Hex digit value; a byte that is not a hex digit counts as itself.
  function automatic logic [7:0] hex_val(input logic [7:0] c);
    if (c >= "0" && c <= "9") begin
      return c - "0";
    end else if (c >= "a" && c <= "f") begin
      return c - "a" + 8'd10;
    end else if (c >= "A" && c <= "F") begin
      return c - "A" + 8'd10;
    end
    return c;
  endfunction

  // One result of the current byte; a byte never causes more than MAX_RESULTS.
  task automatic push_result(input logic [7:0] b, input logic valid, input logic inval,
                             input logic pend, input logic iend);
    qsp_pkg::qsp_result_t r;
    if (caused >= qsp_pkg::MAX_RESULTS) begin
      return;
    end
    r.out_byte = b;
    r.byte_valid = valid;
    r.in_value = inval;
    r.param_end = pend;
    r.input_end = iend;
    r.param_total = params_done[15:0];
    expected_results.push_back(r);
    caused++;
  endtask

  // The parameter counter saturates before the marker carries it out.
  task automatic finish_param(input logic iend);
    if (params_done < COUNT_MAX) begin
      params_done++;
    end
    push_result(8'h00, 1'b0, 1'b0, 1'b1, iend);
  endtask

  task automatic value_byte(input logic [7:0] c);
    if (cfg_plus && c == qsp_pkg::CH_PLUS) begin
      c = qsp_pkg::CH_SPACE;
    end
    push_result(c, 1'b1, 1'b1, 1'b0, 1'b0);
  endtask

  // A percent escape cut short comes out literally; a held '%' digit stays literal,
  // any other held digit is an ordinary value byte.
  task automatic flush_escape();
    if (esc_held >= 2'd1) begin
      push_result(qsp_pkg::CH_PCT, 1'b1, 1'b1, 1'b0, 1'b0);
    end
    if (esc_held >= 2'd2) begin
      if (esc_first == qsp_pkg::CH_PCT) begin
        push_result(qsp_pkg::CH_PCT, 1'b1, 1'b1, 1'b0, 1'b0);
      end else begin
        value_byte(esc_first);
      end
    end
    esc_held = 2'd0;
    esc_first = 8'h00;
  endtask

  // Works out the results of one accepted byte and appends them to the queue.
  task automatic parse_byte(input logic [7:0] b, input logic last);
    logic [7:0] decoded;
    caused = 0;
    if (cur_phase == qsp_pkg::PH_START) begin
      if (cfg_skip) begin
        cur_phase = qsp_pkg::PH_SKIP;
      end else begin
        cur_phase = qsp_pkg::PH_KEY;
      end
      esc_held = 2'd0;
      esc_first = 8'h00;
      params_done = 32'd0;
    end
    if (cur_phase == qsp_pkg::PH_SKIP) begin
      if (b == qsp_pkg::CH_QMARK) begin
        cur_phase = qsp_pkg::PH_KEY;
        if (last) begin
          finish_param(1'b1);
        end
      end else if (last) begin
        params_done = 32'd0;
        push_result(8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
      end
    end else begin
      if (cur_phase == qsp_pkg::PH_KEY) begin
        if (b == qsp_pkg::CH_AMP) begin
          finish_param(1'b0);
        end else if (b == qsp_pkg::CH_EQ) begin
          cur_phase = qsp_pkg::PH_VALUE;
        end else begin
          push_result(b, 1'b1, 1'b0, 1'b0, 1'b0);
        end
      end else if (b == qsp_pkg::CH_AMP) begin
        flush_escape();
        finish_param(1'b0);
        cur_phase = qsp_pkg::PH_KEY;
      end else if (esc_held == 2'd0) begin
        if (b == qsp_pkg::CH_PCT) begin
          esc_held = 2'd1;
        end else begin
          value_byte(b);
        end
      end else if (esc_held == 2'd1) begin
        esc_first = b;
        esc_held = 2'd2;
      end else begin
        decoded = hex_val(esc_first) * 8'd16 + hex_val(b);
        push_result(decoded, 1'b1, 1'b1, 1'b0, 1'b0);
        esc_held = 2'd0;
        esc_first = 8'h00;
      end
      if (last) begin
        flush_escape();
        finish_param(1'b1);
      end
    end
    if (last) begin
      cur_phase = qsp_pkg::PH_START;
      esc_held = 2'd0;
      esc_first = 8'h00;
      params_done = 32'd0;
    end
  endtask

  // Sends one request, idling first at random. Valid is left high after the
  // handshake so that back-to-back requests never lower and raise it in one step.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= last;
    do begin
      @(posedge clk);
    end while (!s_tready);
    parse_byte(b, last);
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i], i == s.len() - 1);
    end
  endtask

  // Waits until every expected result has come out and the pipeline is empty.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register write: setup cycle, access cycle, then the bus is released.
  task automatic write_reg(input logic idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (idx == qsp_pkg::REG_SKIP_TO_QUERY) begin
      cfg_skip = val[0];
    end else begin
      cfg_plus = val[0];
    end
    @(posedge clk);
  endtask

  // Register read; prdata is sampled at the edge that completes the access.
  task automatic check_reg(input logic idx, input logic want);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== {31'd0, want}) begin
      report_error($sformatf("register %0d read %h, expected %h", idx, prdata,
                             {31'd0, want}));
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Changes both settings with the parser idle and reads them back.
  task automatic set_mode(input logic skip, input logic plus);
    wait_idle();
    write_reg(qsp_pkg::REG_SKIP_TO_QUERY, {31'd0, skip});
    write_reg(qsp_pkg::REG_DECODE_PLUS, {31'd0, plus});
    check_reg(qsp_pkg::REG_SKIP_TO_QUERY, skip);
    check_reg(qsp_pkg::REG_DECODE_PLUS, plus);
  endtask

  // Mostly the characters that steer the parser, with a share of arbitrary bytes
  // so that every bit of the byte field is exercised.
  function automatic logic [7:0] pick_char();
    string hex_chars = "0123456789abcdefABCDEF";
    int r;
    r = $urandom_range(99);
    if (r < 25) begin
      return hex_chars[$urandom_range(21)];
    end else if (r < 35) begin
      return qsp_pkg::CH_EQ;
    end else if (r < 45) begin
      return qsp_pkg::CH_AMP;
    end else if (r < 60) begin
      return qsp_pkg::CH_PCT;
    end else if (r < 68) begin
      return qsp_pkg::CH_PLUS;
    end else if (r < 73) begin
      return qsp_pkg::CH_QMARK;
    end else if (r < 85) begin
      return 8'($urandom_range(255));
    end
    return 8'("g" + $urandom_range(19));
  endfunction

  // Both registers come out of reset set.
  task automatic test_register_reset();
    check_reg(qsp_pkg::REG_SKIP_TO_QUERY, 1'b1);
    check_reg(qsp_pkg::REG_DECODE_PLUS, 1'b1);
  endtask

  // Query mode with plus decoding: the corner cases of skipping and escapes.
  task automatic test_query_cases();
    set_mode(1'b1, 1'b1);
    // A string without a question mark gives only the end marker.
    send_str("x");
    // A lone question mark ends one empty parameter.
    send_str("?");
    // Escape, plus sign, and an ampersand as the final byte.
    send_str("?=%4f+&");
    // A percent with one byte left: literal percent, then the plus decodes.
    send_str("?=%+");
    // An ampersand right after the percent still ends the parameter.
    send_str("a?=%&");
  endtask

  // Form mode without plus decoding, with the extreme byte values.
  task automatic test_form_cases();
    set_mode(1'b0, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(qsp_pkg::CH_EQ, 1'b0);
    send_byte(qsp_pkg::CH_PCT, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(qsp_pkg::CH_PLUS, 1'b1);
    // Two percent signs at the end of a value both come out literally.
    send_str("=%%");
  endtask

  // Random strings under one setting and one pattern of idling and stalls.
  task automatic test_random(input logic skip, input logic plus, input int idle_pct,
                             input int stall_pct, input int n_bytes);
    logic [7:0] text[$];
    int sent;
    int len;
    set_mode(skip, plus);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_bytes) begin
      text.delete();
      // In query mode most strings carry a short path and a question mark.
      if (skip && $urandom_range(99) < 85) begin
        repeat ($urandom_range(3)) text.push_back(8'("a" + $urandom_range(25)));
        text.push_back(qsp_pkg::CH_QMARK);
      end
      len = $urandom_range(14);
      repeat (len) text.push_back(pick_char());
      if (text.size() == 0) begin
        text.push_back(pick_char());
      end
      foreach (text[i]) begin
        send_byte(text[i], i == text.size() - 1);
      end
      sent += text.size();
    end
    wait_idle();
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  // Compares every result taken from the parser with the oldest expectation,
  // and picks the receiver's ready for the next cycle.
  always @(posedge clk) begin
    qsp_pkg::qsp_result_t seen;
    qsp_pkg::qsp_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      seen.out_byte = m_tdata[7:0];
      seen.param_total = m_tdata[23:8];
      seen.byte_valid = m_tuser[0];
      seen.in_value = m_tuser[1];
      seen.param_end = m_tuser[2];
      seen.input_end = m_tlast;
      if (expected_results.size() == 0) begin
        report_error({"unexpected result ", fmt_result(seen)});
      end else begin
        want = expected_results.pop_front();
        if (seen !== want) begin
          report_error({"expected ", fmt_result(want), " got ", fmt_result(seen)});
        end
      end
    end
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Main sequence: reset once, directed cases, then random phases that walk
  // through all four settings and all idling patterns.
  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = 8'h00;
    s_tlast = 1'b0;
    m_tready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = 3'd0;
    pwdata = 32'd0;
    cfg_skip = 1'b1;
    cfg_plus = 1'b1;
    cur_phase = qsp_pkg::PH_START;
    esc_held = 2'd0;
    esc_first = 8'h00;
    params_done = 32'd0;
    caused = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_register_reset();
    test_query_cases();
    test_form_cases();
    test_random(1'b1, 1'b1, 0, 0, 42);
    test_random(1'b0, 1'b0, 48, 0, 42);
    test_random(1'b1, 1'b0, 0, 48, 42);
    test_random(1'b0, 1'b1, 23, 23, 42);

    if (expected_results.size() != 0) begin
      report_error($sformatf("%0d expected results never arrived",
                             expected_results.size()));
    end
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog for a parser that stops accepting bytes or producing results.
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule

// ----- query_string_parser.f -----
src/qsp_pkg.sv
src/qsp_front.sv
src/qsp_queue.sv
src/qsp_back.sv
src/query_string_parser.sv
sim/query_string_parser_tb.sv
